// ----- src/modal_coefficient_product_assert.svh -----
// Assertion macros shared by the modal coefficient product block.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef MODAL_COEFFICIENT_PRODUCT_ASSERT_SVH
`define MODAL_COEFFICIENT_PRODUCT_ASSERT_SVH
`ifndef SYNTHESIS
`define MCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define MCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define MCP_ASSERT_IMP(lbl, ante, cons)
`define MCP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/mcp_pkg.sv -----
package mcp_pkg;

  localparam int NCOEF         = 5;
  localparam int COEF_W        = 32;
  localparam int ORDER_W       = 3;
  localparam int MAX_ORDER_DEF = 5;
  localparam logic [ORDER_W-1:0] ORDER_RST = 3'd5;

  // Q format of the coefficients and of the triple-product table
  localparam int FRAC_BITS = 16;
  localparam int TAB_FRAC  = 16;
  localparam int RND_SHIFT = FRAC_BITS + TAB_FRAC;

  // products, per-k lane stages
  localparam int NSTAGE  = 5;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int GRP_W   = PROD_W + 3;
  localparam int LO_W    = 34;
  localparam int HI_W    = GRP_W - LO_W;
  localparam int CONST_W = TAB_FRAC + 1;
  localparam int PL_W    = LO_W + CONST_W;
  localparam int PH_W    = HI_W + CONST_W + 1;
  localparam int NCONST  = 10;
  localparam int SUM_W   = PH_W + 4;
  localparam int ACC_W   = SUM_W + LO_W + 1;

  typedef enum logic [3:0] {
    CK_ONE,
    CK_486,
    CK_6_11,
    CK_6_7,
    CK_2S5_5,
    CK_4S5_15,
    CK_2S5_7,
    CK_20S5_77,
    CK_3R105,
    CK_4R21,
    CK_NONE
  } tri_const_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t prod_arr_t [NCOEF][NCOEF];

  // load enables of the lane stages
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } mcp_ld_t;

  // triple-product constants, unsigned Q1.16
  function automatic logic [CONST_W-1:0] tri_value(input tri_const_t c);
    logic [CONST_W-1:0] v;
    case (c)
      CK_ONE:     v = 17'd65536;
      CK_486:     v = 17'd31819;
      CK_6_11:    v = 17'd35747;
      CK_6_7:     v = 17'd56174;
      CK_2S5_5:   v = 17'd58617;
      CK_4S5_15:  v = 17'd39078;
      CK_2S5_7:   v = 17'd41869;
      CK_20S5_77: v = 17'd38063;
      CK_3R105:   v = 17'd57561;
      CK_4R21:    v = 17'd57205;
      default:    v = '0;
    endcase
    return v;
  endfunction

  // which constant weighs a[i]*b[j] in output k; code is {i, j, k} in octal
  function automatic tri_const_t tri_index(input int i, input int j, input int k);
    logic [8:0] code;
    tri_const_t r;
    code = {i[2:0], j[2:0], k[2:0]};
    case (code)
      9'o000, 9'o110, 9'o220, 9'o330, 9'o440,
      9'o011, 9'o101, 9'o022, 9'o202,
      9'o033, 9'o303, 9'o044, 9'o404:        r = CK_ONE;
      9'o121, 9'o211, 9'o112:                r = CK_2S5_5;
      9'o231, 9'o321, 9'o132, 9'o312,
      9'o123, 9'o213:                        r = CK_3R105;
      9'o341, 9'o431, 9'o143, 9'o413,
      9'o134, 9'o314:                        r = CK_4R21;
      9'o222:                                r = CK_2S5_7;
      9'o242, 9'o422, 9'o224:                r = CK_6_7;
      9'o332, 9'o233, 9'o323:                r = CK_4S5_15;
      9'o442, 9'o244, 9'o424:                r = CK_20S5_77;
      9'o343, 9'o433, 9'o334:                r = CK_6_11;
      9'o444:                                r = CK_486;
      default:                               r = CK_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- src/mcp_lane.sv -----
module mcp_lane #(
  parameter int K = 0
) (
  input  logic                             clk,
  input  mcp_pkg::mcp_ld_t                 ld,
  input  logic [mcp_pkg::ORDER_W-1:0]      n_eff,
  input  mcp_pkg::prod_arr_t               prod,
  output logic signed [mcp_pkg::COEF_W-1:0] coef
);

  logic signed [mcp_pkg::GRP_W-1:0] grp_nxt [mcp_pkg::NCONST];
  logic signed [mcp_pkg::GRP_W-1:0] grp_r   [mcp_pkg::NCONST];
  logic        [mcp_pkg::PL_W-1:0]  pl_nxt  [mcp_pkg::NCONST];
  logic        [mcp_pkg::PL_W-1:0]  pl_r    [mcp_pkg::NCONST];
  logic signed [mcp_pkg::PH_W-1:0]  ph_nxt  [mcp_pkg::NCONST];
  logic signed [mcp_pkg::PH_W-1:0]  ph_r    [mcp_pkg::NCONST];
  logic        [mcp_pkg::SUM_W-1:0] lo_nxt, lo_r;
  logic signed [mcp_pkg::SUM_W-1:0] hi_nxt, hi_r;
  logic signed [mcp_pkg::ACC_W-1:0] acc, rs;
  logic                             ovf;
  logic signed [mcp_pkg::COEF_W-1:0] coef_nxt, coef_r;

  // group products that share a constant, drop those beyond the order
  always_comb begin
    for (int c = 0; c < mcp_pkg::NCONST; c++) begin
      grp_nxt[c] = '0;
      for (int i = 0; i < mcp_pkg::NCOEF; i++) begin
        for (int j = 0; j < mcp_pkg::NCOEF; j++) begin
          if (mcp_pkg::tri_index(i, j, K) == mcp_pkg::tri_const_t'(c) &&
              mcp_pkg::ORDER_W'(i) < n_eff && mcp_pkg::ORDER_W'(j) < n_eff) begin
            grp_nxt[c] = grp_nxt[c] + mcp_pkg::GRP_W'(prod[i][j]);
          end
        end
      end
    end
  end

  // weigh each group: low and high halves times the constant
  always_comb begin
    for (int c = 0; c < mcp_pkg::NCONST; c++) begin
      pl_nxt[c] = mcp_pkg::PL_W'(grp_r[c][mcp_pkg::LO_W-1:0]) *
                  mcp_pkg::PL_W'(mcp_pkg::tri_value(mcp_pkg::tri_const_t'(c)));
      ph_nxt[c] = mcp_pkg::PH_W'($signed(grp_r[c][mcp_pkg::GRP_W-1:mcp_pkg::LO_W])) *
                  $signed(mcp_pkg::PH_W'(mcp_pkg::tri_value(mcp_pkg::tri_const_t'(c))));
    end
  end

  // sum the halves; the rounding offset rides in the low sum
  always_comb begin
    lo_nxt = mcp_pkg::SUM_W'(1) << (mcp_pkg::RND_SHIFT - 1);
    hi_nxt = '0;
    for (int c = 0; c < mcp_pkg::NCONST; c++) begin
      lo_nxt = lo_nxt + mcp_pkg::SUM_W'(pl_r[c]);
      hi_nxt = hi_nxt + mcp_pkg::SUM_W'(ph_r[c]);
    end
  end

  // join, shift out the fraction, saturate, zero above the order
  always_comb begin
    acc = (mcp_pkg::ACC_W'(hi_r) <<< mcp_pkg::LO_W) + mcp_pkg::ACC_W'(lo_r);
    rs  = acc >>> mcp_pkg::RND_SHIFT;
    ovf = !((&rs[mcp_pkg::ACC_W-1:mcp_pkg::COEF_W-1]) ||
            !(|rs[mcp_pkg::ACC_W-1:mcp_pkg::COEF_W-1]));
    if (mcp_pkg::ORDER_W'(K) >= n_eff) begin
      coef_nxt = '0;
    end else if (ovf) begin
      coef_nxt = rs[mcp_pkg::ACC_W-1] ? {1'b1, {(mcp_pkg::COEF_W-1){1'b0}}}
                                      : {1'b0, {(mcp_pkg::COEF_W-1){1'b1}}};
    end else begin
      coef_nxt = rs[mcp_pkg::COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      grp_r <= grp_nxt;
    end
    if (ld.ld3) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (ld.ld4) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (ld.ld5) begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ----- src/modal_coefficient_product.sv -----
// Projected product of two five-term modal expansions, one cell per item.
// in_:  tdata carries a_coef_0..4 then b_coef_0..4, 32-bit signed each.
// out_: tdata carries prod_coef_0..4, 32-bit signed, rounded and saturated.
// cfg_: a write of cfg_wr_data sets order_in_use; values above the maximum
//       order act as the maximum. Write it only while no item is in flight.
// Five register stages: products of all coefficient pairs, constant groups,
// group times table constant (split in two halves), half sums, final
// round/saturate into the output register. Throughput is one item per cycle
// while out_tready stays high, set by the per-pair multipliers.
// Each stage advances on its own: a stalled receiver holds the output
// register, and input keeps flowing into empty stages behind it until the
// pipeline fills; in_tready then drops until the output transfer.
// Reset clears all stage valid bits and sets order_in_use to 5.
`include "modal_coefficient_product_assert.svh"
module modal_coefficient_product #(
  parameter int MAX_ORDER = mcp_pkg::MAX_ORDER_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // a_coef_0, a_coef_1, .. a_coef_4, b_coef_0, .. b_coef_4
  input  logic [2*mcp_pkg::NCOEF*mcp_pkg::COEF_W-1:0]      in_tdata,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // prod_coef_0, prod_coef_1, .. prod_coef_4
  output logic [mcp_pkg::NCOEF*mcp_pkg::COEF_W-1:0]        out_tdata,
  input  logic                                             cfg_wr_en,
  input  logic [mcp_pkg::ORDER_W-1:0]                      cfg_wr_data
);

  logic [mcp_pkg::ORDER_W-1:0] order_r;
  logic [mcp_pkg::ORDER_W-1:0] n_eff;
  logic [mcp_pkg::NSTAGE-1:0]  vld_r, vld_nxt, adv;
  logic signed [mcp_pkg::COEF_W-1:0] a_v [mcp_pkg::NCOEF];
  logic signed [mcp_pkg::COEF_W-1:0] b_v [mcp_pkg::NCOEF];
  mcp_pkg::prod_arr_t          prod_nxt, prod_r;
  mcp_pkg::mcp_ld_t            ld;
  logic                        in_acc, out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= mcp_pkg::ORDER_RST;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  assign n_eff = (order_r > mcp_pkg::ORDER_W'(MAX_ORDER)) ? mcp_pkg::ORDER_W'(MAX_ORDER)
                                                          : order_r;

  // a stage advances when it is empty or the one after it advances
  always_comb begin
    adv[mcp_pkg::NSTAGE-1] = !vld_r[mcp_pkg::NSTAGE-1] || out_tready;
    for (int s = mcp_pkg::NSTAGE - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int s = 1; s < mcp_pkg::NSTAGE; s++) begin
      vld_nxt[s] = adv[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[mcp_pkg::NSTAGE-1];
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  assign ld = '{ld2: adv[1], ld3: adv[2], ld4: adv[3], ld5: adv[4]};

  // one signed 32x32 product per coefficient pair
  always_comb begin
    for (int i = 0; i < mcp_pkg::NCOEF; i++) begin
      a_v[i] = $signed(in_tdata[i*mcp_pkg::COEF_W +: mcp_pkg::COEF_W]);
      b_v[i] = $signed(in_tdata[(mcp_pkg::NCOEF+i)*mcp_pkg::COEF_W +: mcp_pkg::COEF_W]);
    end
    for (int i = 0; i < mcp_pkg::NCOEF; i++) begin
      for (int j = 0; j < mcp_pkg::NCOEF; j++) begin
        if (i < MAX_ORDER && j < MAX_ORDER) begin
          prod_nxt[i][j] = mcp_pkg::PROD_W'(a_v[i]) * mcp_pkg::PROD_W'(b_v[j]);
        end else begin
          prod_nxt[i][j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_r <= prod_nxt;
    end
  end

  for (genvar k = 0; k < mcp_pkg::NCOEF; k++) begin : g_lane
    mcp_lane #(
      .K(k)
    ) u_lane (
      .clk   (clk),
      .ld    (ld),
      .n_eff (n_eff),
      .prod  (prod_r),
      .coef  (out_tdata[k*mcp_pkg::COEF_W +: mcp_pkg::COEF_W])
    );
  end

  // a ready sink always lets the pipeline take input
  `MCP_ASSERT_IMP(a_ready_follows_sink, out_tready, in_tready)
  // occupancy moves only with transfers on the two channels
  `MCP_ASSERT_NXT(a_occupancy, 1'b1, $countones(vld_r) == $countones($past(vld_r)) + int'($past(in_acc)) - int'($past(out_acc)))

endmodule

// ----- sim/modal_coefficient_product_checker.sv -----
`timescale 1ns / 100ps

module modal_coefficient_product_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  input  logic                                        in_tready,
  // a_coef_0, a_coef_1, .. a_coef_4, b_coef_0, .. b_coef_4
  input  logic [2*mcp_pkg::NCOEF*mcp_pkg::COEF_W-1:0] in_tdata,
  input  logic                                        out_tvalid,
  input  logic                                        out_tready,
  // prod_coef_0, prod_coef_1, .. prod_coef_4
  input  logic [mcp_pkg::NCOEF*mcp_pkg::COEF_W-1:0]   out_tdata,
  input  logic                                        cfg_wr_en,
  input  logic [mcp_pkg::ORDER_W-1:0]                 cfg_wr_data,
  output int                                          fail_count,
  output int                                          pending_results
);
  import mcp_pkg::*;

  localparam int TABLE_FRAC = 16;
  localparam int SHIFT      = FRAC_BITS + TABLE_FRAC;
  localparam int ACC_BITS   = 128;

  // triple-product weights, unsigned Q16.16
  localparam int unsigned W_ONE      = 65536;
  localparam int unsigned W_486      = 31819;
  localparam int unsigned W_6_11     = 35747;
  localparam int unsigned W_6_7      = 56174;
  localparam int unsigned W_2S5_5    = 58617;
  localparam int unsigned W_4S5_15   = 39078;
  localparam int unsigned W_2S5_7    = 41869;
  localparam int unsigned W_20S5_77  = 38063;
  localparam int unsigned W_3R105    = 57561;
  localparam int unsigned W_4R21     = 57205;

  localparam logic signed [ACC_BITS-1:0] HALF_LSB = 128'sd1 <<< (SHIFT - 1);
  localparam logic signed [ACC_BITS-1:0] Q_MAX    = 128'sh7FFF_FFFF;
  localparam logic signed [ACC_BITS-1:0] Q_MIN    = -128'sh8000_0000;

  typedef logic [2*NCOEF-1:0][COEF_W-1:0] coef_pair_t;
  typedef logic [NCOEF-1:0][COEF_W-1:0]   prod_vec_t;

  int unsigned tri_weight [NCOEF][NCOEF][NCOEF];
  prod_vec_t   expected_products [$];
  prod_vec_t   seen_vec;
  prod_vec_t   want_vec;
  logic [ORDER_W-1:0] order_copy = ORDER_RST;
  int          mismatches = 0;

  // the weight depends only on the set of indexes, so store every permutation
  task automatic set_weight(input int i, input int j, input int k, input int unsigned w);
    tri_weight[i][j][k] = w;
    tri_weight[i][k][j] = w;
    tri_weight[j][i][k] = w;
    tri_weight[j][k][i] = w;
    tri_weight[k][i][j] = w;
    tri_weight[k][j][i] = w;
  endtask

  initial begin
    foreach (tri_weight[i, j, k]) tri_weight[i][j][k] = 0;
    set_weight(0, 0, 0, W_ONE);
    set_weight(0, 1, 1, W_ONE);
    set_weight(0, 2, 2, W_ONE);
    set_weight(0, 3, 3, W_ONE);
    set_weight(0, 4, 4, W_ONE);
    set_weight(1, 1, 2, W_2S5_5);
    set_weight(1, 2, 3, W_3R105);
    set_weight(1, 3, 4, W_4R21);
    set_weight(2, 2, 2, W_2S5_7);
    set_weight(2, 2, 4, W_6_7);
    set_weight(2, 3, 3, W_4S5_15);
    set_weight(2, 4, 4, W_20S5_77);
    set_weight(3, 3, 4, W_6_11);
    set_weight(4, 4, 4, W_486);
  end

  function automatic prod_vec_t project_product(input coef_pair_t coefs,
                                                input logic [ORDER_W-1:0] order);
    logic signed [ACC_BITS-1:0] acc;
    logic signed [ACC_BITS-1:0] term;
    logic signed [ACC_BITS-1:0] wv;
    longint    pa;
    longint    pb;
    int        n;
    prod_vec_t res;
    n = (order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(order);
    res = '0;
    for (int k = 0; k < n; k++) begin
      acc = '0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          pa = $signed(coefs[i]);
          pb = $signed(coefs[NCOEF + j]);
          wv = tri_weight[i][j][k];
          term = pa * pb;
          acc = acc + term * wv;
        end
      end
      // round half up, then clamp to 32 bits
      acc = (acc + HALF_LSB) >>> SHIFT;
      if (acc > Q_MAX) acc = Q_MAX;
      if (acc < Q_MIN) acc = Q_MIN;
      res[k] = acc[COEF_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_products.delete();
      order_copy = ORDER_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_vec = out_tdata;
        if (expected_products.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          mismatches++;
        end else begin
          want_vec = expected_products.pop_front();
          for (int k = 0; k < NCOEF; k++) begin
            if (seen_vec[k] !== want_vec[k]) begin
              $error("prod_coef_%0d: expected %0d, actual %0d", k,
                     $signed(want_vec[k]), $signed(seen_vec[k]));
              mismatches++;
            end
          end
        end
      end
      // predict with the order in force before any write at this edge
      if (in_tvalid && in_tready)
        expected_products.push_back(project_product(in_tdata, order_copy));
      if (cfg_wr_en)
        order_copy = cfg_wr_data;
    end
    fail_count      <= mismatches;
    pending_results <= expected_products.size();
  end

endmodule

// ----- sim/modal_coefficient_product_tb.sv -----
`timescale 1ns / 100ps

module modal_coefficient_product_tb;
  import mcp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 120;

  typedef logic [2*NCOEF-1:0][COEF_W-1:0] coef_pair_t;

  localparam logic [COEF_W-1:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] C_UNIT = 32'h0001_0000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*NCOEF*COEF_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [NCOEF*COEF_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [ORDER_W-1:0] cfg_wr_data = '0;

  int fail_count;
  int pending_results;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cycles = 0;

  int phase_order [9] = '{1, 7, 3, 0, 4, 6, 2, 5, 5};

  modal_coefficient_product dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  modal_coefficient_product_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [COEF_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = '0;
          3: v = 32'd1;
          4: v = '1;
          5: v = C_UNIT;
          default: v = -C_UNIT;
        endcase
      end
      1, 2: ;
      3, 4, 5, 6: v = {{11{v[20]}}, v[20:0]};
      default: v = {{5{v[26]}}, v[26:0]};
    endcase
    return v;
  endfunction

  function automatic coef_pair_t rand_pair();
    coef_pair_t p;
    for (int i = 0; i < 2*NCOEF; i++) p[i] = rand_coef();
    return p;
  endfunction

  task automatic send_item(input coef_pair_t d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and hold until every result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    coef_pair_t d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset order
    d = '0;
    send_item(d);
    for (int i = 0; i < 2*NCOEF; i++) d[i] = C_MAX;
    send_item(d);
    for (int i = 0; i < 2*NCOEF; i++) d[i] = C_MIN;
    send_item(d);
    for (int i = 0; i < NCOEF; i++) d[i] = C_MAX;
    send_item(d);
    d = '0;
    d[0] = C_UNIT;
    d[NCOEF] = C_UNIT;
    send_item(d);
    // exact half of an output LSB, positive and negative
    d[0] = 32'h0000_8000;
    d[NCOEF] = 32'd1;
    send_item(d);
    d[0] = 32'hFFFF_8000;
    send_item(d);
    d = '0;
    d[NCOEF-1] = C_UNIT;
    d[2*NCOEF-1] = C_UNIT;
    send_item(d);
    for (int i = 1; i < 4; i++) begin
      d = '0;
      d[i] = C_UNIT;
      for (int j = 0; j < NCOEF; j++) d[NCOEF + j] = C_UNIT;
      send_item(d);
    end
    for (int i = 0; i < 2*NCOEF; i++) d[i] = (i < NCOEF) ? '1 : 32'd1;
    send_item(d);

    // sweep every order value, including the ones above the maximum
    for (int i = 0; i < 2*NCOEF; i++) d[i] = C_UNIT;
    for (int o = 0; o < 8; o++) begin
      write_order(o[ORDER_W-1:0]);
      send_item(d);
    end

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin tx_idle_pct = 25; rx_idle_pct = 46; end
        1: begin tx_idle_pct = 46; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_order(phase_order[p][ORDER_W-1:0]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        send_item(rand_pair());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
